>>> design/sync_word_frame_deframer_macros.svh
// ---------------------------------------------------------------------------
// sync_word_frame_deframer assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH
`define SYNC_WORD_FRAME_DEFRAMER_MACROS_SVH

// same-cycle implication
`define SWFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWFD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/swfd_pkg.sv
// ---------------------------------------------------------------------------
// swfd_pkg
// Types and constants of the sync word / type / length deframer.
// ---------------------------------------------------------------------------
`default_nettype none

package swfd_pkg;

	localparam int unsigned ByteW = 8;
	localparam int unsigned WordW = 32;
	localparam int unsigned WordBytes = WordW / ByteW;
	localparam int unsigned FillW = $clog2(WordBytes + 1);
	localparam int unsigned SeenW = $clog2(WordBytes);

	localparam logic [WordW-1:0] SYNC_WORD_RESET = 32'hA5A5_A5A5;

	typedef enum logic [3:0] {
		PH_HUNT    = 4'b0001,
		PH_TYPE    = 4'b0010,
		PH_LEN     = 4'b0100,
		PH_PAYLOAD = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] frame_type;
		logic [ByteW-1:0] payload_byte;
		logic             first_of_frame;
		logic             last_of_frame;
		logic             empty_frame;
	} res_t;

endpackage

`default_nettype wire

>>> design/swfd_parse.sv
// ---------------------------------------------------------------------------
// swfd_parse
// Header parser: sync hunt, type and length capture, payload tagging.
// ---------------------------------------------------------------------------
`default_nettype none

module swfd_parse
	import swfd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [WordW-1:0] cfg_wdata,
	input  wire logic             take,
	input  wire logic [ByteW-1:0] data_byte,
	output logic                  emit,
	output res_t                  res
);

	phase_t            phase_q, phase_d;
	logic [WordW-1:0]  sync_q;
	logic [WordW-1:0]  window_q, window_d;
	logic [FillW-1:0]  fill_q, fill_d;
	logic [ByteW-1:0]  type_q, type_d;
	logic [WordW-1:0]  len_q, len_d;
	logic [SeenW-1:0]  seen_q, seen_d;
	logic [WordW-1:0]  remain_q, remain_d;
	logic              first_q, first_d;
	logic [WordW-1:0]  shifted_win;
	logic [WordW-1:0]  shifted_len;
	logic [WordW-1:0]  remain_dec;
	logic              win_full;

	assign shifted_win = {window_q[WordW-ByteW-1:0], data_byte};
	assign shifted_len = {len_q[WordW-ByteW-1:0], data_byte};
	assign remain_dec  = remain_q - WordW'(1);
	assign win_full    = (fill_q >= FillW'(WordBytes - 1));

	always_comb begin
		phase_d  = phase_q;
		window_d = window_q;
		fill_d   = fill_q;
		type_d   = type_q;
		len_d    = len_q;
		seen_d   = seen_q;
		remain_d = remain_q;
		first_d  = first_q;
		emit     = 1'b0;
		res.frame_type     = type_q;
		res.payload_byte   = data_byte;
		res.first_of_frame = first_q;
		res.last_of_frame  = (remain_q == WordW'(1));
		res.empty_frame    = 1'b0;
		case (phase_q)
			PH_HUNT: begin
				window_d = shifted_win;
				if (fill_q < FillW'(WordBytes))
					fill_d = fill_q + FillW'(1);
				if (win_full && shifted_win == sync_q) begin
					phase_d  = PH_TYPE;
					window_d = '0;
					fill_d   = '0;
				end
			end
			PH_TYPE: begin
				type_d  = data_byte;
				len_d   = '0;
				seen_d  = '0;
				phase_d = PH_LEN;
			end
			PH_LEN: begin
				len_d  = shifted_len;
				seen_d = seen_q + SeenW'(1);
				if (seen_q == SeenW'(WordBytes - 1)) begin
					if (shifted_len == '0) begin
						emit = 1'b1;
						res.payload_byte   = '0;
						res.first_of_frame = 1'b1;
						res.last_of_frame  = 1'b1;
						res.empty_frame    = 1'b1;
						phase_d = PH_HUNT;
					end else begin
						remain_d = shifted_len;
						first_d  = 1'b1;
						phase_d  = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (remain_q == '0) begin
					phase_d = PH_HUNT;
					first_d = 1'b1;
				end else begin
					emit     = 1'b1;
					remain_d = remain_dec;
					first_d  = 1'b0;
					if (remain_dec == '0) begin
						phase_d = PH_HUNT;
						first_d = 1'b1;
					end
				end
			end
			default: begin
				phase_d = PH_HUNT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q <= SYNC_WORD_RESET;
		end else if (cfg_we) begin
			sync_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			window_q <= '0;
			fill_q   <= '0;
			type_q   <= '0;
			len_q    <= '0;
			seen_q   <= '0;
			remain_q <= '0;
			first_q  <= 1'b1;
		end else if (take) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			fill_q   <= fill_d;
			type_q   <= type_d;
			len_q    <= len_d;
			seen_q   <= seen_d;
			remain_q <= remain_d;
			first_q  <= first_d;
		end
	end

endmodule

`default_nettype wire

>>> design/swfd_outreg.sv
// ---------------------------------------------------------------------------
// swfd_outreg
// Result register with valid/ready toward the consumer.
// ---------------------------------------------------------------------------
`default_nettype none

module swfd_outreg
	import swfd_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic load,
	input  wire logic load_valid,
	input  wire res_t load_res,
	input  wire logic res_ready,
	output logic      res_valid,
	output logic      slot_free,
	output res_t      res
);

	logic valid_q;
	res_t res_q;

	assign slot_free = !valid_q || res_ready;
	assign res_valid = valid_q;
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= load_valid;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && load_valid) begin
			res_q <= load_res;
		end
	end

endmodule

`default_nettype wire

>>> design/sync_word_frame_deframer.sv
// ---------------------------------------------------------------------------
// sync_word_frame_deframer
// Hunts a 32-bit sync word in a byte stream, reads type and length, and
// emits the payload bytes tagged with type and first/last marks, or one empty-frame result.
// ---------------------------------------------------------------------------
//   channel    handshake                    payload
//   input      data_valid / data_ready      data_byte
//   result     res_valid / res_ready        frame_type, payload_byte,
//                                           first_of_frame, last_of_frame,
//                                           empty_frame
//   config     sync_word_we                 sync_word_wdata
//
// One byte per cycle while data_ready is high; a result shows in the cycle after its byte is taken.
// data_ready falls only while a result is held and res_ready is low.
// arst_n clears the parser to hunting and the sync word to A5A5A5A5.
// ---------------------------------------------------------------------------
`default_nettype none

module sync_word_frame_deframer
	import swfd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             sync_word_we,
	input  wire logic [WordW-1:0] sync_word_wdata,
	input  wire logic             data_valid,
	output logic                  data_ready,
	input  wire logic [ByteW-1:0] data_byte,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic [ByteW-1:0]      frame_type,
	output logic [ByteW-1:0]      payload_byte,
	output logic                  first_of_frame,
	output logic                  last_of_frame,
	output logic                  empty_frame
);

	logic take;
	logic emit;
	logic slot_free;
	res_t parse_res;
	res_t out_res;

	assign data_ready = slot_free;
	assign take       = data_valid && slot_free;

	swfd_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (sync_word_we),
		.cfg_wdata (sync_word_wdata),
		.take      (take),
		.data_byte (data_byte),
		.emit      (emit),
		.res       (parse_res)
	);

	swfd_outreg u_outreg (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (take),
		.load_valid (emit),
		.load_res   (parse_res),
		.res_ready  (res_ready),
		.res_valid  (res_valid),
		.slot_free  (slot_free),
		.res        (out_res)
	);

	assign frame_type     = out_res.frame_type;
	assign payload_byte   = out_res.payload_byte;
	assign first_of_frame = out_res.first_of_frame;
	assign last_of_frame  = out_res.last_of_frame;
	assign empty_frame    = out_res.empty_frame;

endmodule

`default_nettype wire

>>> design/swfd_checker.sv
// ---------------------------------------------------------------------------
// swfd_checker
// Port-level checks on the deframer, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sync_word_frame_deframer_macros.svh"

module swfd_checker
	import swfd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             data_valid,
	input wire logic             data_ready,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire logic [ByteW-1:0] frame_type,
	input wire logic [ByteW-1:0] payload_byte,
	input wire logic             first_of_frame,
	input wire logic             last_of_frame,
	input wire logic             empty_frame
);

	`SWFD_ASSERT_NOW(a_empty_marks, res_valid && empty_frame,
		first_of_frame && last_of_frame && payload_byte == '0,
		"empty frame result without first/last marks or with data")

	`SWFD_ASSERT_NOW(a_stall_only_full, !data_ready, res_valid && !res_ready,
		"input stalled while result slot can drain")

	`SWFD_ASSERT_NOW(a_result_from_input, $rose(res_valid),
		$past(data_valid && data_ready),
		"result appeared without an input transaction")

	`SWFD_ASSERT_NXT(a_result_hold, res_valid && !res_ready,
		res_valid && $stable(frame_type) && $stable(payload_byte)
			&& $stable(first_of_frame) && $stable(last_of_frame)
			&& $stable(empty_frame),
		"stalled result changed")

endmodule

bind sync_word_frame_deframer swfd_checker u_swfd_checker (.*);

`default_nettype wire

>>> verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: sync word / type / length deframer testbench
// Feeds byte streams of clean frames, noise and damaged headers under several
// sync word settings, with random gaps on both channels. A scoreboard tracks
// the parser state on every accepted byte and checks each result transaction
// field by field against the oldest expected one.
// ---------------------------------------------------------------------------
module tb_top;
	import swfd_pkg::*;

	class frame_scoreboard;
		logic [WordW-1:0] sync_word;
		phase_t           phase;
		logic [WordW-1:0] hunt_window;
		logic [FillW-1:0] window_fill;
		logic [ByteW-1:0] held_type;
		logic [WordW-1:0] length_shift;
		logic [SeenW-1:0] length_seen;
		logic [WordW-1:0] bytes_left;
		logic             first_next;
		res_t             expected_q[$];
		int unsigned      errors, results, frames, empties;

		function new();
			sync_word    = SYNC_WORD_RESET;
			phase        = PH_HUNT;
			hunt_window  = '0;
			window_fill  = '0;
			held_type    = '0;
			length_shift = '0;
			length_seen  = '0;
			bytes_left   = '0;
			first_next   = 1'b1;
			errors       = 0;
			results      = 0;
			frames       = 0;
			empties      = 0;
		endfunction

		// true when this byte would complete the sync word
		function bit would_match(logic [ByteW-1:0] b);
			return phase == PH_HUNT && window_fill >= WordBytes - 1 &&
				{hunt_window[WordW-ByteW-1:0], b} == sync_word;
		endfunction

		function void note_byte(logic [ByteW-1:0] b);
			res_t r;
			case (phase)
			PH_HUNT: begin
				hunt_window = {hunt_window[WordW-ByteW-1:0], b};
				if (window_fill < WordBytes)
					window_fill++;
				if (window_fill == WordBytes && hunt_window == sync_word) begin
					phase       = PH_TYPE;
					hunt_window = '0;
					window_fill = '0;
				end
			end
			PH_TYPE: begin
				held_type    = b;
				length_shift = '0;
				length_seen  = '0;
				phase        = PH_LEN;
			end
			PH_LEN: begin
				length_shift = {length_shift[WordW-ByteW-1:0], b};
				if (length_seen == SeenW'(WordBytes - 1)) begin
					length_seen = '0;
					if (length_shift == '0) begin
						r.frame_type     = held_type;
						r.payload_byte   = '0;
						r.first_of_frame = 1'b1;
						r.last_of_frame  = 1'b1;
						r.empty_frame    = 1'b1;
						expected_q.push_back(r);
						frames++;
						empties++;
						phase = PH_HUNT;
					end else begin
						bytes_left = length_shift;
						first_next = 1'b1;
						phase      = PH_PAYLOAD;
					end
				end else begin
					length_seen++;
				end
			end
			default: begin
				if (bytes_left == '0) begin
					phase      = PH_HUNT;
					first_next = 1'b1;
				end else begin
					r.frame_type     = held_type;
					r.payload_byte   = b;
					r.first_of_frame = first_next;
					r.last_of_frame  = (bytes_left == 1);
					r.empty_frame    = 1'b0;
					expected_q.push_back(r);
					if (first_next)
						frames++;
					bytes_left--;
					first_next = 1'b0;
					if (bytes_left == '0) begin
						phase      = PH_HUNT;
						first_next = 1'b1;
					end
				end
			end
			endcase
		endfunction

		task report(string what);
			errors++;
			if (errors <= 20)
				$display("%0t mismatch: %s", $time, what);
		endtask

		task check(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected result type %02h byte %02h",
					got.frame_type, got.payload_byte));
				return;
			end
			want = expected_q.pop_front();
			results++;
			if (got.frame_type !== want.frame_type)
				report($sformatf("frame_type %02h, want %02h",
					got.frame_type, want.frame_type));
			if (got.payload_byte !== want.payload_byte)
				report($sformatf("payload_byte %02h, want %02h",
					got.payload_byte, want.payload_byte));
			if (got.first_of_frame !== want.first_of_frame)
				report($sformatf("first_of_frame %b, want %b",
					got.first_of_frame, want.first_of_frame));
			if (got.last_of_frame !== want.last_of_frame)
				report($sformatf("last_of_frame %b, want %b",
					got.last_of_frame, want.last_of_frame));
			if (got.empty_frame !== want.empty_frame)
				report($sformatf("empty_frame %b, want %b",
					got.empty_frame, want.empty_frame));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             sync_word_we;
	logic [WordW-1:0] sync_word_wdata;
	logic             data_valid;
	logic             data_ready;
	logic [ByteW-1:0] data_byte;
	logic             res_valid;
	logic             res_ready;
	logic [ByteW-1:0] frame_type;
	logic [ByteW-1:0] payload_byte;
	logic             first_of_frame;
	logic             last_of_frame;
	logic             empty_frame;

	frame_scoreboard sb = new();

	bit          calm;
	bit          long_hold_req;
	int unsigned bytes_sent;
	int unsigned settings_used;

	sync_word_frame_deframer i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.sync_word_we    (sync_word_we),
		.sync_word_wdata (sync_word_wdata),
		.data_valid      (data_valid),
		.data_ready      (data_ready),
		.data_byte       (data_byte),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.frame_type      (frame_type),
		.payload_byte    (payload_byte),
		.first_of_frame  (first_of_frame),
		.last_of_frame   (last_of_frame),
		.empty_frame     (empty_frame)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// a byte that appears nowhere in the sync word, so it breaks any partial match
	function automatic logic [ByteW-1:0] guard_byte();
		logic [ByteW-1:0] g;
		do
			g = ByteW'($urandom_range(0, 255));
		while (g == sb.sync_word[31:24] || g == sb.sync_word[23:16] ||
			g == sb.sync_word[15:8] || g == sb.sync_word[7:0]);
		return g;
	endfunction

	task automatic send_byte(logic [ByteW-1:0] b);
		int unsigned gap;
		gap = pick_gap();
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		do
			@(posedge clk);
		while (!data_ready);
		sb.note_byte(b);
		bytes_sent++;
	endtask

	task automatic send_word(logic [WordW-1:0] w);
		for (int i = WordBytes - 1; i >= 0; i--)
			send_byte(w[i*ByteW +: ByteW]);
	endtask

	// noise, guard, then either a damaged header or a clean frame
	task automatic send_frame();
		int unsigned      n, r, k;
		logic [WordW-1:0] len, bad;
		logic [ByteW-1:0] b, flip;
		n = $urandom_range(0, 6);
		repeat (n) begin
			if ($urandom_range(0, 1))
				b = sb.sync_word[ByteW*$urandom_range(0, 3) +: ByteW];
			else
				b = ByteW'($urandom_range(0, 255));
			if (sb.would_match(b))
				b = guard_byte();
			send_byte(b);
		end
		send_byte(guard_byte());
		if ($urandom_range(0, 99) < 10) begin
			k    = $urandom_range(0, 3);
			flip = ByteW'($urandom_range(1, 255));
			bad  = sb.sync_word ^ (WordW'(flip) << (ByteW * k));
			send_word(bad);
			return;
		end
		send_word(sb.sync_word);
		send_byte(ByteW'($urandom_range(0, 255)));
		r = $urandom_range(0, 99);
		if (r < 10)
			len = '0;
		else if (r < 85)
			len = $urandom_range(1, 16);
		else if (r < 97)
			len = $urandom_range(17, 200);
		else
			len = $urandom_range(201, 600);
		send_word(len);
		for (int unsigned i = 0; i < len; i++) begin
			if ($urandom_range(0, 6) == 0)
				send_byte(sb.sync_word[ByteW*$urandom_range(0, 3) +: ByteW]);
			else
				send_byte(ByteW'($urandom_range(0, 255)));
		end
	endtask

	task automatic send_frames_until(int unsigned target);
		while (bytes_sent < target)
			send_frame();
	endtask

	// drain, let the parser settle, then write the sync word
	task automatic write_sync(logic [WordW-1:0] value);
		data_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		sync_word_we    <= 1'b1;
		sync_word_wdata <= value;
		@(posedge clk);
		sync_word_we <= 1'b0;
		sb.sync_word = value;
		settings_used++;
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			sb.check({frame_type, payload_byte, first_of_frame, last_of_frame, empty_frame});
	end

	initial begin
		int unsigned n;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (300) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					res_ready <= 1'b0;
					repeat (n) @(posedge clk);
				end
			end
			res_ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin
		#4_800_000;
		$display("status: fail");
		$finish;
	end

	initial begin
		arst_n          = 1'b0;
		sync_word_we    = 1'b0;
		sync_word_wdata = '0;
		data_valid      = 1'b0;
		data_byte       = '0;
		res_ready       = 1'b0;
		calm            = 1'b0;
		long_hold_req   = 1'b0;
		bytes_sent      = 0;
		settings_used   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sliding window, empty frame, one-byte frame at the byte extremes
		send_byte(8'h00);
		send_byte(8'hFF);
		send_word(SYNC_WORD_RESET);
		send_byte(8'h00);
		send_word(32'h0);
		send_word(SYNC_WORD_RESET);
		send_byte(8'hFF);
		send_word(32'h1);
		send_byte(8'hFF);
		send_frames_until(420);

		// zero sync word: no match before four bytes, none inside the payload
		write_sync(32'h0);
		repeat (4) send_byte(8'h00);
		send_byte(8'h5A);
		send_word(32'h6);
		repeat (6) send_byte(8'h00);
		send_frames_until(820);

		write_sync(32'hFFFF_FFFF);
		long_hold_req = 1'b1;
		send_frames_until(1220);

		write_sync($urandom());
		send_frames_until(1620);

		write_sync(SYNC_WORD_RESET);
		calm = 1'b1;
		send_frames_until(1950);

		// longest length: stays in the payload to the end of the run
		send_byte(guard_byte());
		send_word(sb.sync_word);
		send_byte(ByteW'($urandom_range(0, 255)));
		send_word(32'hFFFF_FFFF);
		repeat (40) send_byte(ByteW'($urandom_range(0, 255)));

		data_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("run covered %0d bytes under %0d sync word settings, incl. a long output stall",
			bytes_sent, settings_used + 1);
		$display("%0d frames seen (%0d empty), %0d result transactions checked, %0d errors",
			sb.frames, sb.empties, sb.results, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
